FILE: rtl/requester_id_record_table_defines.svh
// Assertion macros shared by the requester id record table RTL
`ifndef REQUESTER_ID_RECORD_TABLE_DEFINES_SVH
`define REQUESTER_ID_RECORD_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RIT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rit_pkg.sv
// Types and constants of the requester id record table
package rit_pkg;

  localparam int unsigned SEG_W      = 16;
  localparam int unsigned BUS_W      = 8;
  localparam int unsigned DEVFN_W    = 8;
  localparam int unsigned OWNER_W    = 4;
  localparam int unsigned QDEP_W     = 8;
  localparam int unsigned SID_W      = 16;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned OUT_IDX_W  = 6;
  localparam int unsigned CMD_W      = 2;

  // largest ATS invalidate queue depth a request may ask for
  localparam logic [QDEP_W-1:0] MAX_QUEUE_DEPTH = 8'd32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_NOPERM   = 3'd2,
    ST_BUSY     = 3'd3,
    ST_NOSPACE  = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  // stored record, 26 bits
  typedef struct packed {
    logic [QDEP_W-1:0] qdepth;
    logic              ats_en;
    logic              ats_sup;
    logic [SID_W-1:0]  source_id;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [SEG_W-1:0]   segment;
    logic [BUS_W-1:0]   bus;
    logic [DEVFN_W-1:0] devfn;
    logic [OWNER_W-1:0] owner_id;
    logic [SEG_W-1:0]   owner_segment;
    logic               ats_sup;
    logic               ats_en;
    logic [QDEP_W-1:0]  qdepth;
    logic               in_satc;
    logic               owner_dit;
    logic [SID_W-1:0]   source_id;
  } in_beat_t;

endpackage

FILE: rtl/rit_ifs.sv
// Valid/ready channel interfaces for request and result beats
interface rit_in_if;
  logic                          valid;
  logic                          ready;
  logic [rit_pkg::CMD_W-1:0]     cmd;
  logic [rit_pkg::SEG_W-1:0]     segment;
  logic [rit_pkg::BUS_W-1:0]     bus;
  logic [rit_pkg::DEVFN_W-1:0]   devfn;
  logic [rit_pkg::OWNER_W-1:0]   owner_id;
  logic [rit_pkg::SEG_W-1:0]     owner_segment;
  logic                          ats_sup;
  logic                          ats_en;
  logic [rit_pkg::QDEP_W-1:0]    qdepth;
  logic                          in_satc;
  logic                          owner_dit;
  logic [rit_pkg::SID_W-1:0]     source_id;

  modport source (
    output valid, cmd, segment, bus, devfn, owner_id, owner_segment,
           ats_sup, ats_en, qdepth, in_satc, owner_dit, source_id,
    input  ready
  );
  modport sink (
    input  valid, cmd, segment, bus, devfn, owner_id, owner_segment,
           ats_sup, ats_en, qdepth, in_satc, owner_dit, source_id,
    output ready
  );
endinterface

interface rit_out_if;
  logic                          valid;
  logic                          ready;
  logic [rit_pkg::STATUS_W-1:0]  status;
  logic [rit_pkg::OUT_IDX_W-1:0] slot_index;
  logic [rit_pkg::SID_W-1:0]     stored_source_id;
  logic                          stored_ats_sup;
  logic                          stored_ats_en;
  logic [rit_pkg::QDEP_W-1:0]    stored_qdepth;

  modport source (
    output valid, status, slot_index, stored_source_id, stored_ats_sup,
           stored_ats_en, stored_qdepth,
    input  ready
  );
  modport sink (
    input  valid, status, slot_index, stored_source_id, stored_ats_sup,
           stored_ats_en, stored_qdepth,
    output ready
  );
endinterface

FILE: rtl/rit_ram.sv
// Generic single-write, single-read RAM with registered read data
module rit_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/requester_id_record_table.sv
// Requester id record table: keyed device records with first-free allocation
//
//   channel | dir | beat
//   --------+-----+---------------------------------------------------
//   in_ch   | in  | command, requester key, owner, ATS and SATC info
//   out_ch  | out | status, slot index, stored record
//
// One beat per cycle sustained while out_ch.ready is high; a result passes the
// input register, then the result register with the record RAM read.
// Key match and first-free search run combinationally in parallel over all slots.
// Reset clears the used map at once; keys, owners and records are not reset.
// A stalled result holds the pipe; in_ch.ready drops only when both stages fill.
`include "requester_id_record_table_defines.svh"

module requester_id_record_table #(
  parameter int unsigned SLOTS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  rit_in_if.sink   in_ch,
  rit_out_if.source out_ch
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  // request stage
  logic              a_valid_r;
  rit_pkg::in_beat_t a_r;
  logic              a_fire;
  logic              b_free;

  // table
  logic [SLOTS-1:0]                 used_r;
  logic [SLOTS-1:0]                 used_nxt;
  logic [rit_pkg::KEY_W-1:0]        key_r   [SLOTS];
  logic [rit_pkg::OWNER_W-1:0]      owner_r [SLOTS];

  // search results
  logic [rit_pkg::KEY_W-1:0] key;
  logic [SLOTS-1:0]          key_hit;
  logic [SLOTS-1:0]          own_hit;
  logic                      key_any;
  logic                      own_any;
  logic [IDX_W-1:0]          hit_idx;
  logic [IDX_W-1:0]          free_idx;
  logic                      free_any;

  // decode
  rit_pkg::status_t   status_nxt;
  logic [IDX_W-1:0]   slot_nxt;
  rit_pkg::rec_t      rec_nxt;
  rit_pkg::rec_t      new_rec;
  logic               use_ram_nxt;
  logic               alloc_ok;
  logic               rd_req;
  logic               rm_ok;
  logic [IDX_W+5:0]   slot_ext;

  // result stage
  logic                              b_valid_r;
  rit_pkg::status_t                  status_r;
  logic [rit_pkg::OUT_IDX_W-1:0]     slot_r;
  rit_pkg::rec_t                     rec_r;
  logic                              use_ram_r;
  logic [rit_pkg::REC_W-1:0]         ram_rdata;
  rit_pkg::rec_t                     out_rec;

  assign b_free      = !b_valid_r || out_ch.ready;
  assign in_ch.ready = !a_valid_r || b_free;
  assign a_fire      = a_valid_r && b_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      a_r <= '{cmd: in_ch.cmd, segment: in_ch.segment, bus: in_ch.bus,
               devfn: in_ch.devfn, owner_id: in_ch.owner_id,
               owner_segment: in_ch.owner_segment,
               ats_sup: in_ch.ats_sup, ats_en: in_ch.ats_en,
               qdepth: in_ch.qdepth, in_satc: in_ch.in_satc,
               owner_dit: in_ch.owner_dit, source_id: in_ch.source_id};
    end
  end

  // fully associative match and first-free priority encoder
  assign key = {a_r.segment, a_r.bus, a_r.devfn};

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      key_hit[i] = used_r[i] && (key_r[i] == key);
      own_hit[i] = key_hit[i] && (owner_r[i] == a_r.owner_id);
      // keys are unique among used slots, so at most one hit
      if (key_hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign key_any  = |key_hit;
  assign own_any  = |own_hit;
  assign free_any = !(&used_r);

  always_comb begin
    new_rec.source_id = (a_r.in_satc && a_r.owner_dit) ? {a_r.bus, a_r.devfn}
                                                       : a_r.source_id;
    new_rec.ats_sup   = a_r.ats_sup;
    new_rec.ats_en    = a_r.ats_en;
    new_rec.qdepth    = a_r.qdepth;
  end

  always_comb begin
    status_nxt  = rit_pkg::ST_INVALID;
    slot_nxt    = '0;
    rec_nxt     = '0;
    use_ram_nxt = 1'b0;
    alloc_ok    = 1'b0;
    rd_req      = 1'b0;
    rm_ok       = 1'b0;
    unique case (rit_pkg::cmd_t'(a_r.cmd))
      rit_pkg::CMD_ALLOC: begin
        if (a_r.segment != a_r.owner_segment || a_r.qdepth > rit_pkg::MAX_QUEUE_DEPTH ||
            (a_r.ats_en && !a_r.ats_sup)) begin
          status_nxt = rit_pkg::ST_INVALID;
        end else if (!a_r.in_satc && (a_r.ats_sup || a_r.ats_en)) begin
          status_nxt = rit_pkg::ST_NOPERM;
        end else if (key_any) begin
          status_nxt = rit_pkg::ST_BUSY;
        end else if (!free_any) begin
          status_nxt = rit_pkg::ST_NOSPACE;
        end else begin
          status_nxt = rit_pkg::ST_OK;
          slot_nxt   = free_idx;
          rec_nxt    = new_rec;
          alloc_ok   = 1'b1;
        end
      end
      rit_pkg::CMD_LOOKUP: begin
        if (a_r.segment != a_r.owner_segment) begin
          status_nxt = rit_pkg::ST_INVALID;
        end else if (!own_any) begin
          status_nxt = rit_pkg::ST_NOTFOUND;
        end else begin
          status_nxt  = rit_pkg::ST_OK;
          slot_nxt    = hit_idx;
          use_ram_nxt = 1'b1;
          rd_req      = 1'b1;
        end
      end
      rit_pkg::CMD_REMOVE: begin
        if (!key_any) begin
          status_nxt = rit_pkg::ST_NOTFOUND;
        end else begin
          status_nxt  = rit_pkg::ST_OK;
          slot_nxt    = hit_idx;
          use_ram_nxt = 1'b1;
          rd_req      = 1'b1;
          rm_ok       = 1'b1;
        end
      end
      default: begin
        status_nxt = rit_pkg::ST_INVALID;
      end
    endcase
  end

  // reported slot number is masked to the output width
  assign slot_ext = {6'b0, slot_nxt};

  always_comb begin
    used_nxt = used_r;
    if (a_fire && alloc_ok) begin
      used_nxt[free_idx] = 1'b1;
    end
    if (a_fire && rm_ok) begin
      used_nxt[hit_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
    if (a_fire && alloc_ok) begin
      key_r[free_idx]   <= key;
      owner_r[free_idx] <= a_r.owner_id;
    end
  end

  rit_ram #(
    .WIDTH (rit_pkg::REC_W),
    .DEPTH (SLOTS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (a_fire && alloc_ok),
    .waddr (free_idx),
    .wdata (new_rec),
    .re    (a_fire && rd_req),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_free) begin
      b_valid_r <= a_valid_r;
    end
    if (a_fire) begin
      status_r  <= status_nxt;
      slot_r    <= slot_ext[5:0];
      rec_r     <= rec_nxt;
      use_ram_r <= use_ram_nxt;
    end
  end

  assign out_rec = use_ram_r ? rit_pkg::rec_t'(ram_rdata) : rec_r;

  assign out_ch.valid            = b_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.slot_index       = slot_r;
  assign out_ch.stored_source_id = out_rec.source_id;
  assign out_ch.stored_ats_sup   = out_rec.ats_sup;
  assign out_ch.stored_ats_en    = out_rec.ats_en;
  assign out_ch.stored_qdepth    = out_rec.qdepth;

  `RIT_ASSERT_NOW(a_key_unique, clk, rst_n, 1'b1, $onehot0(key_hit), "duplicate key in table")
  `RIT_ASSERT_NEXT(a_alloc_sets_used, clk, rst_n, a_fire && alloc_ok, used_r[$past(free_idx)], "allocated slot not marked used")
  `RIT_ASSERT_NOW(a_nospace_only_full, clk, rst_n, a_valid_r && status_nxt == rit_pkg::ST_NOSPACE, &used_r, "no space reported with a free slot")
  `RIT_ASSERT_NEXT(a_remove_frees, clk, rst_n, a_fire && rm_ok, !used_r[$past(hit_idx)], "removed slot still marked used")

endmodule
